@@ sv/kprsc_pkg.sv @@
// Shared constants, widths and helpers for the keypad row scanner with code queue.
package kprsc_pkg;

    // Queue and matrix dimensions.
    localparam int RING_DEPTH = 32;
    localparam int MAX_ROWS   = 8;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // Field widths.
    localparam int PORT_W     = 16;
    localparam int CODE_W     = 8;
    localparam int ROW_CNT_W  = 4;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_ROW_COUNT = 3'd0;
    localparam logic [ROW_CNT_W-1:0]  ROW_COUNT_RESET = 4'd8;

    // Item kinds carried on the input tuser bit.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // Word layouts.
    localparam int IN_DATA_W  = 3 * PORT_W;
    localparam int OUT_DATA_W = 24;

    // Next position of a ring pointer, wrapping from the last entry to zero.
    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W:0] inc;
        begin
            inc = {1'b0, p} + {{PTR_W{1'b0}}, 1'b1};
            if (inc >= (PTR_W + 1)'(RING_DEPTH))
            begin
                ring_next = '0;
            end
            else
            begin
                ring_next = inc[PTR_W-1:0];
            end
        end
    endfunction

endpackage

@@ sv/keypad_row_scan_change_fifo.sv @@
// Keypad matrix row scanner that queues changed column codes in a ring.
//
// Input stream (s_axis_*): one word per item. tuser selects the kind of
// item: a sample of the currently selected row, or a pop of the oldest
// queued column code. tdata carries the three raw port words.
// Output stream (m_axis_*): exactly one result word per input word, in
// order. It gives the active-low drive for the row that the next sample
// scans, the popped code, and the empty, pushed and overflow flags.
// Configuration (APB): the row_count register at byte address 0 sets how
// many rows are scanned before the row counter wraps; write it only while
// no word is in flight.
// The result is registered and shows in the cycle after its word is accepted.
// All state is updated at the accepting edge, so while the receiver does
// not stall a new word can be accepted every cycle: one word per cycle.
// The result register doubles as the output buffer: while the receiver
// stalls, the held result keeps its value and s_axis_tready drops only
// when that register is full and not being drained in the same cycle.
// Reset clears the row counter, the stored row codes and both queue
// pointers, and sets row_count to 8. Queue entries are not cleared; only
// written entries are ever read. The queue holds RING_DEPTH - 1 codes; a
// changed code arriving at a full queue is dropped and flagged.
module keypad_row_scan_change_fifo
    import kprsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // APB configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: port_c_word [15:0], port_f_word [31:16], port_a_word [47:32]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: op [0]
    input  logic                  s_axis_tuser,

    // Output stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: row_drive [7:0], scan_code [15:8], fifo_empty [16],
    // code_pushed [17], overflow [18], zero fill [23:19]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // Configuration register.
    logic [ROW_CNT_W-1:0] row_count_reg;
    logic                 cfg_write;

    // Scanner and queue state.
    logic [ROW_W-1:0]     current_row_reg;
    logic [ROW_W-1:0]     current_row_next;
    logic [CODE_W-1:0]    last_cols_reg [MAX_ROWS];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CODE_W-1:0]    ring_mem [RING_DEPTH];
    logic [CODE_W-1:0]    ring_rd_reg;

    // Result register.
    logic                 out_valid_reg;
    logic [CODE_W-1:0]    row_drive_reg;
    logic                 pop_hit_reg;
    logic                 empty_reg;
    logic                 pushed_reg;
    logic                 ovf_reg;

    // Per-word combinational results.
    logic                 accept;
    logic                 is_pop;
    logic [PORT_W-1:0]    port_c;
    logic [PORT_W-1:0]    port_f;
    logic [PORT_W-1:0]    port_a;
    logic [CODE_W-1:0]    sample_code;
    logic                 row_changed;
    logic                 ring_empty;
    logic                 ring_full;
    logic                 do_push;
    logic                 do_pop;
    logic [ROW_CNT_W-1:0] eff_rows;
    logic [ROW_CNT_W-1:0] row_plus1;

    // ------------------------------------------------------------------
    // APB: always ready, one register at byte address zero.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == REG_ROW_COUNT);

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_ROW_COUNT)
        begin
            prdata = {{(APB_DATA_W - ROW_CNT_W){1'b0}}, row_count_reg};
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The result register frees up when it is empty or being
    // taken in this cycle.
    // ------------------------------------------------------------------
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_pop        = (s_axis_tuser == OP_POP);

    assign port_c = s_axis_tdata[PORT_W-1:0];
    assign port_f = s_axis_tdata[2*PORT_W-1:PORT_W];
    assign port_a = s_axis_tdata[3*PORT_W-1:2*PORT_W];

    // Column lines are active low; invert so that a set bit is a pressed key.
    // Columns 1-4 from port C bits 0-3, 5-6 from port F bits 2-3, 7-8 from
    // port A bits 0-1.
    assign sample_code = {~port_a[1:0], ~port_f[3:2], ~port_c[3:0]};

    assign row_changed = (last_cols_reg[current_row_reg] != sample_code);
    assign ring_empty  = (rd_ptr_reg == wr_ptr_reg);
    assign ring_full   = (ring_next(wr_ptr_reg) == rd_ptr_reg);

    assign do_push = accept && !is_pop && row_changed && !ring_full;
    assign do_pop  = accept && is_pop && !ring_empty;

    // A row count of zero behaves as one, and anything above the matrix
    // height behaves as the full height.
    always_comb
    begin
        if (row_count_reg == '0)
        begin
            eff_rows = ROW_CNT_W'(1);
        end
        else if (row_count_reg > ROW_CNT_W'(MAX_ROWS))
        begin
            eff_rows = ROW_CNT_W'(MAX_ROWS);
        end
        else
        begin
            eff_rows = row_count_reg;
        end
    end

    // The counter wraps once it reaches the row count, which also covers
    // the case where the count was lowered below the current row.
    assign row_plus1 = ROW_CNT_W'(current_row_reg) + ROW_CNT_W'(1);

    always_comb
    begin
        current_row_next = current_row_reg;
        if (accept && !is_pop)
        begin
            if (row_plus1 >= eff_rows)
            begin
                current_row_next = '0;
            end
            else
            begin
                current_row_next = row_plus1[ROW_W-1:0];
            end
        end
    end

    assign wr_ptr_next = do_push ? ring_next(wr_ptr_reg) : wr_ptr_reg;
    assign rd_ptr_next = do_pop  ? ring_next(rd_ptr_reg) : rd_ptr_reg;

    // ------------------------------------------------------------------
    // Control state and result register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg   <= ROW_COUNT_RESET;
            current_row_reg <= '0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                last_cols_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                row_count_reg <= pwdata[ROW_CNT_W-1:0];
            end

            current_row_reg <= current_row_next;
            wr_ptr_reg      <= wr_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;

            // The row's stored code follows every sample, even when the
            // queue was full and the change was dropped.
            if (accept && !is_pop)
            begin
                last_cols_reg[current_row_reg] <= sample_code;
            end

            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; loaded only when a word is accepted, so it holds
    // through a stall.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_drive_reg <= ~(CODE_W'(1) << current_row_next);
            pop_hit_reg   <= do_pop;
            empty_reg     <= is_pop && ring_empty;
            pushed_reg    <= do_push;
            ovf_reg       <= !is_pop && row_changed && ring_full;
        end
    end

    // ------------------------------------------------------------------
    // Code queue memory: one write and one registered read per cycle.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ring_mem[wr_ptr_reg] <= sample_code;
        end
        if (do_pop)
        begin
            ring_rd_reg <= ring_mem[rd_ptr_reg];
        end
    end

    // ------------------------------------------------------------------
    // Output word.
    // ------------------------------------------------------------------
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, ovf_reg, pushed_reg, empty_reg,
                            (pop_hit_reg ? ring_rd_reg : {CODE_W{1'b0}}),
                            row_drive_reg};

endmodule
